// File: rtl/core/prime_factorization_assert.svh
// assertion macros for the prime factorization block
`ifndef PRIME_FACTORIZATION_ASSERT_SVH
`define PRIME_FACTORIZATION_ASSERT_SVH

// same-cycle implication
`define PF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pf assertion failed");

// next-cycle implication
`define PF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pf assertion failed");

`endif

// File: rtl/core/pf_pkg.sv
// package: constants, microcode types and microcode rom of the prime factorization block
package pf_pkg;

  localparam int NUMBER_WIDTH_DEF = 31;
  localparam int MAX_RESULTS      = 9;
  localparam int EXP_W            = 5;
  localparam int CNT_W            = 4;
  localparam int UPC_W            = 5;

  localparam logic [EXP_W-1:0] EXP_MAX = EXP_W'(31);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RESULTS);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_START,
    OP_TAKE,
    OP_PUSH,
    OP_INC_D,
    OP_PUSH_REM,
    OP_FLUSH,
    OP_EMPTY
  } op_t;

  typedef enum logic [3:0] {
    C_FALSE,
    C_IN_VALID,
    C_SMALL,
    C_CNT_FULL,
    C_SQ_GT_REM,
    C_DIV_DONE,
    C_REM_ZERO,
    C_PEND_BLOCKED,
    C_OUT_FREE,
    C_FIN_PUSH
  } cond_t;

  typedef struct packed {
    logic in_valid;
    logic small_val;
    logic cnt_full;
    logic sq_gt_rem;
    logic div_done;
    logic rem_zero;
    logic pend_blocked;
    logic out_free;
    logic fin_push;
  } pf_status_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic             invert;
    logic [UPC_W-1:0] target;
  } ucode_t;

  localparam logic [UPC_W-1:0] U_IDLE      = UPC_W'(0);
  localparam logic [UPC_W-1:0] U_CHECK     = UPC_W'(1);
  localparam logic [UPC_W-1:0] U_LOOP      = UPC_W'(2);
  localparam logic [UPC_W-1:0] U_BOUND     = UPC_W'(3);
  localparam logic [UPC_W-1:0] U_TRY       = UPC_W'(4);
  localparam logic [UPC_W-1:0] U_TRY_WAIT  = UPC_W'(5);
  localparam logic [UPC_W-1:0] U_TRY_TEST  = UPC_W'(6);
  localparam logic [UPC_W-1:0] U_TAKE      = UPC_W'(7);
  localparam logic [UPC_W-1:0] U_AGAIN     = UPC_W'(8);
  localparam logic [UPC_W-1:0] U_AGAIN_W   = UPC_W'(9);
  localparam logic [UPC_W-1:0] U_AGAIN_T   = UPC_W'(10);
  localparam logic [UPC_W-1:0] U_EMIT_W    = UPC_W'(11);
  localparam logic [UPC_W-1:0] U_EMIT      = UPC_W'(12);
  localparam logic [UPC_W-1:0] U_INC_D     = UPC_W'(13);
  localparam logic [UPC_W-1:0] U_FINISH    = UPC_W'(14);
  localparam logic [UPC_W-1:0] U_FIN_W     = UPC_W'(15);
  localparam logic [UPC_W-1:0] U_FIN_PUSH  = UPC_W'(16);
  localparam logic [UPC_W-1:0] U_FLUSH_W   = UPC_W'(17);
  localparam logic [UPC_W-1:0] U_FLUSH     = UPC_W'(18);
  localparam logic [UPC_W-1:0] U_EMPTY_W   = UPC_W'(19);
  localparam logic [UPC_W-1:0] U_EMPTY     = UPC_W'(20);

  // each step runs its op, then jumps to target when (cond ^ invert), else falls through
  function automatic ucode_t pf_ucode(input logic [UPC_W-1:0] a);
    ucode_t w;
    unique case (a)
      U_IDLE:     w = '{OP_LOAD,      C_IN_VALID,     1'b1, U_IDLE};
      U_CHECK:    w = '{OP_NOP,       C_SMALL,        1'b0, U_EMPTY_W};
      U_LOOP:     w = '{OP_NOP,       C_CNT_FULL,     1'b0, U_FINISH};
      U_BOUND:    w = '{OP_NOP,       C_SQ_GT_REM,    1'b0, U_FINISH};
      U_TRY:      w = '{OP_DIV_START, C_FALSE,        1'b0, U_IDLE};
      U_TRY_WAIT: w = '{OP_NOP,       C_DIV_DONE,     1'b1, U_TRY_WAIT};
      U_TRY_TEST: w = '{OP_NOP,       C_REM_ZERO,     1'b1, U_INC_D};
      U_TAKE:     w = '{OP_TAKE,      C_FALSE,        1'b0, U_IDLE};
      U_AGAIN:    w = '{OP_DIV_START, C_FALSE,        1'b0, U_IDLE};
      U_AGAIN_W:  w = '{OP_NOP,       C_DIV_DONE,     1'b1, U_AGAIN_W};
      U_AGAIN_T:  w = '{OP_NOP,       C_REM_ZERO,     1'b0, U_TAKE};
      U_EMIT_W:   w = '{OP_NOP,       C_PEND_BLOCKED, 1'b0, U_EMIT_W};
      U_EMIT:     w = '{OP_PUSH,      C_FALSE,        1'b0, U_IDLE};
      U_INC_D:    w = '{OP_INC_D,     C_FALSE,        1'b1, U_LOOP};
      U_FINISH:   w = '{OP_NOP,       C_FIN_PUSH,     1'b1, U_FLUSH_W};
      U_FIN_W:    w = '{OP_NOP,       C_PEND_BLOCKED, 1'b0, U_FIN_W};
      U_FIN_PUSH: w = '{OP_PUSH_REM,  C_FALSE,        1'b0, U_IDLE};
      U_FLUSH_W:  w = '{OP_NOP,       C_OUT_FREE,     1'b1, U_FLUSH_W};
      U_FLUSH:    w = '{OP_FLUSH,     C_FALSE,        1'b1, U_IDLE};
      U_EMPTY_W:  w = '{OP_NOP,       C_OUT_FREE,     1'b1, U_EMPTY_W};
      U_EMPTY:    w = '{OP_EMPTY,     C_FALSE,        1'b1, U_IDLE};
      default:    w = '{OP_NOP,       C_FALSE,        1'b1, U_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/pf_divider.sv
// pf_divider: restoring divider, one quotient bit per cycle
module pf_divider #(
  parameter int NW = pf_pkg::NUMBER_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic [NW-1:0] quot,
  output logic [NW-1:0] rem,
  output logic          done
);

  localparam int CW = $clog2(NW);

  logic [NW-1:0] q;
  logic [NW-1:0] r;
  logic [NW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [NW:0]   r_shift;
  logic [NW:0]   r_sub;

  assign r_shift = {r, q[NW-1]};
  assign r_sub   = r_shift - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(NW - 1);
      q    <= dividend;
      r    <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (r_sub[NW]) begin
        r <= r_shift[NW-1:0];
        q <= {q[NW-2:0], 1'b0};
      end else begin
        r <= r_sub[NW-1:0];
        q <= {q[NW-2:0], 1'b1};
      end
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign quot = q;
  assign rem  = r;

endmodule

// File: rtl/core/pf_datapath.sv
// pf_datapath: remainder, trial divisor, pending result and output register
`include "prime_factorization_assert.svh"

module pf_datapath #(
  parameter int NW = pf_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pf_pkg::op_t                  op,
  input  logic                         in_valid,
  input  logic [NW-1:0]                number,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [NW-1:0]                factor,
  output logic [pf_pkg::EXP_W-1:0]     exponent,
  output logic                         last_factor,
  output logic                         input_is_prime,
  output pf_pkg::pf_status_t           status
);

  logic [NW-1:0]              rem;
  logic [NW-1:0]              d;
  logic [NW:0]                sq;
  logic [pf_pkg::EXP_W-1:0]   e;
  logic [pf_pkg::CNT_W-1:0]   cnt;
  logic                       pend;
  logic [NW-1:0]              pend_factor;
  logic [pf_pkg::EXP_W-1:0]   pend_exp;
  logic                       pend_prime;

  logic [NW-1:0] div_quot;
  logic [NW-1:0] div_rem;
  logic          div_done;
  logic          out_free;
  logic          out_wr;
  logic          load;

  pf_divider #(.NW(NW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (op == pf_pkg::OP_DIV_START),
    .dividend (rem),
    .divisor  (d),
    .quot     (div_quot),
    .rem      (div_rem),
    .done     (div_done)
  );

  assign out_free = !out_valid || out_ready;
  assign load     = (op == pf_pkg::OP_LOAD) && in_valid;
  assign out_wr   = ((op == pf_pkg::OP_PUSH || op == pf_pkg::OP_PUSH_REM) && pend)
                    || op == pf_pkg::OP_FLUSH || op == pf_pkg::OP_EMPTY;

  always_comb begin
    status.in_valid     = in_valid;
    status.small_val    = rem <= NW'(1);
    status.cnt_full     = cnt == pf_pkg::CNT_MAX;
    status.sq_gt_rem    = sq > {1'b0, rem};
    status.div_done     = div_done;
    status.rem_zero     = div_rem == '0;
    status.pend_blocked = pend && !out_free;
    status.out_free     = out_free;
    status.fin_push     = (rem > NW'(1)) && (cnt != pf_pkg::CNT_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (out_wr) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (op)
        pf_pkg::OP_LOAD: begin
          if (load) begin
            rem  <= number;
            d    <= NW'(2);
            sq   <= (NW + 1)'(4);
            e    <= '0;
            cnt  <= '0;
            pend <= 1'b0;
          end
        end
        pf_pkg::OP_TAKE: begin
          rem <= div_quot;
          if (e != pf_pkg::EXP_MAX) begin
            e <= e + 1'b1;
          end
        end
        pf_pkg::OP_PUSH: begin
          if (pend) begin
            factor         <= pend_factor;
            exponent       <= pend_exp;
            last_factor    <= 1'b0;
            input_is_prime <= pend_prime;
          end
          pend        <= 1'b1;
          pend_factor <= d;
          pend_exp    <= e;
          pend_prime  <= 1'b0;
          cnt         <= cnt + 1'b1;
          e           <= '0;
        end
        pf_pkg::OP_PUSH_REM: begin
          if (pend) begin
            factor         <= pend_factor;
            exponent       <= pend_exp;
            last_factor    <= 1'b0;
            input_is_prime <= pend_prime;
          end
          pend        <= 1'b1;
          pend_factor <= rem;
          pend_exp    <= pf_pkg::EXP_W'(1);
          pend_prime  <= !pend;
          cnt         <= cnt + 1'b1;
        end
        pf_pkg::OP_INC_D: begin
          d  <= d + 1'b1;
          sq <= sq + {d, 1'b1};
        end
        pf_pkg::OP_FLUSH: begin
          factor         <= pend_factor;
          exponent       <= pend_exp;
          last_factor    <= 1'b1;
          input_is_prime <= pend_prime;
          pend           <= 1'b0;
        end
        pf_pkg::OP_EMPTY: begin
          factor         <= '0;
          exponent       <= '0;
          last_factor    <= 1'b1;
          input_is_prime <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  `PF_ASSERT_NOW(a_out_write_free, out_wr, out_free)
  `PF_ASSERT_NOW(a_cnt_capped, 1'b1, cnt <= pf_pkg::CNT_MAX)
  `PF_ASSERT_NOW(a_prime_is_last, out_valid && input_is_prime, last_factor)
  `PF_ASSERT_NEXT(a_start_clears_done, op == pf_pkg::OP_DIV_START, !div_done)

endmodule

// File: rtl/core/pf_sequencer.sv
// pf_sequencer: microcode step counter with conditional jumps
module pf_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  pf_pkg::pf_status_t status,
  output pf_pkg::op_t        op
);

  logic [pf_pkg::UPC_W-1:0] upc;
  logic [pf_pkg::UPC_W-1:0] upc_next;
  pf_pkg::ucode_t           uw;
  logic                     cond_val;

  assign uw = pf_pkg::pf_ucode(upc);
  assign op = uw.op;

  always_comb begin
    unique case (uw.cond)
      pf_pkg::C_FALSE:        cond_val = 1'b0;
      pf_pkg::C_IN_VALID:     cond_val = status.in_valid;
      pf_pkg::C_SMALL:        cond_val = status.small_val;
      pf_pkg::C_CNT_FULL:     cond_val = status.cnt_full;
      pf_pkg::C_SQ_GT_REM:    cond_val = status.sq_gt_rem;
      pf_pkg::C_DIV_DONE:     cond_val = status.div_done;
      pf_pkg::C_REM_ZERO:     cond_val = status.rem_zero;
      pf_pkg::C_PEND_BLOCKED: cond_val = status.pend_blocked;
      pf_pkg::C_OUT_FREE:     cond_val = status.out_free;
      pf_pkg::C_FIN_PUSH:     cond_val = status.fin_push;
      default:                cond_val = 1'b0;
    endcase
    upc_next = (cond_val ^ uw.invert) ? uw.target : upc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= pf_pkg::U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// File: rtl/core/prime_factorization.sv
// prime_factorization: top level, trial division factorizer under microcode control
// each trial divisor is tested with one division in the bit-serial divider
// one item tries up to about 46340 trial divisors at 31 bits
// results leave in increasing order, one per distinct prime, from a one-deep output register
// a new item is taken once the final result of the previous one is in the output register
// reset returns the sequencer to idle and empties the output register; no clearing pass
module prime_factorization #(
  parameter int NUMBER_WIDTH = pf_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [NUMBER_WIDTH-1:0]  number,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [NUMBER_WIDTH-1:0]  factor,
  output logic [pf_pkg::EXP_W-1:0] exponent,
  output logic                     last_factor,
  output logic                     input_is_prime
);

  pf_pkg::op_t        op;
  pf_pkg::pf_status_t status;

  assign in_ready = (op == pf_pkg::OP_LOAD);

  pf_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  pf_datapath #(.NW(NUMBER_WIDTH)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .in_valid       (in_valid),
    .number         (number),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .factor         (factor),
    .exponent       (exponent),
    .last_factor    (last_factor),
    .input_is_prime (input_is_prime),
    .status         (status)
  );

endmodule
